### hw/rtl/ipat_pkg.sv
// ----------------------------------------------------------------------------
// ipat_pkg: shared types and constants of the IP alias table
// Item structs, table entry layout, status and opcode codes and the alias
// normalization function.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ipat_pkg;

   // Number of alias characters kept; later characters are cleared.
   localparam int ALIAS_CHARS = 10;
   localparam int ALIAS_BYTES = 10;

   localparam logic [1:0] OP_ADD    = 2'd0;
   localparam logic [1:0] OP_LOOKUP = 2'd1;
   localparam logic [1:0] OP_LOCAL  = 2'd2;
   localparam logic [1:0] OP_SIZE   = 2'd3;

   localparam logic [2:0] ST_OK           = 3'd0;
   localparam logic [2:0] ST_ADDR_EXISTS  = 3'd1;
   localparam logic [2:0] ST_ALIAS_EXISTS = 3'd2;
   localparam logic [2:0] ST_NOT_FOUND    = 3'd3;
   localparam logic [2:0] ST_FULL         = 3'd4;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [31:0] ip_address;
      logic [63:0] alias_head;
      logic [15:0] alias_tail;
   } req_item_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] found_address;
      logic [63:0] found_alias_head;
      logic [15:0] found_alias_tail;
      logic [5:0]  entry_count;
      logic        last;
   } rsp_item_type;

   typedef struct packed {
      logic [31:0] address;
      logic [63:0] alias_head;
      logic [15:0] alias_tail;
   } entry_type;

   localparam int ENTRY_BITS = $bits(entry_type);

   // Upper-cases letters, clears everything after the first zero byte and
   // everything beyond the kept character count.
   function automatic logic [79:0] normalize_alias(input logic [63:0] head,
                                                   input logic [15:0] tail);
      logic [79:0] word;
      logic [79:0] res;
      logic [7:0]  b;
      logic        ended;
      word  = {head, tail};
      res   = '0;
      ended = 1'b0;
      for (int i = 0; i < ALIAS_BYTES; i++) begin
         b = word[79 - 8 * i -: 8];
         if (ended || i >= ALIAS_CHARS) begin
            b = 8'h00;
         end else if (b == 8'h00) begin
            ended = 1'b1;
         end else if (b >= 8'h61 && b <= 8'h7a) begin
            b = b - 8'h20;
         end
         res[79 - 8 * i -: 8] = b;
      end
      return res;
   endfunction

endpackage

`default_nettype wire

### hw/rtl/ipat_ram.sv
// ----------------------------------------------------------------------------
// ipat_ram: generic single write port RAM with registered read
// One write and one read per cycle; read data follows in the next cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ipat_ram #(
   parameter int DATA_WIDTH = 8,
   parameter int DEPTH      = 32,
   parameter int ADDR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                  clock,
   input  wire logic                  wr_en,
   input  wire logic [ADDR_WIDTH-1:0] wr_addr,
   input  wire logic [DATA_WIDTH-1:0] wr_data,
   input  wire logic [ADDR_WIDTH-1:0] rd_addr,
   output      logic [DATA_WIDTH-1:0] rd_data
);

   logic [DATA_WIDTH-1:0] mem_ff [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### hw/rtl/ip_alias_table_core.sv
// An item is taken only in the idle state, passes through the scan (but for a size
// item) and the done state, and then its final result is registered; a lookup hit
// ends the scan early. No new item is taken until the last one is finished.
// The scan reads one entry per cycle, newest first, through the single RAM read port,
// unless a locality match waits for the result register; a result that waits for a
// stalled one adds the wait. Reset: synchronous, active high; clears count and control, not RAM.
// ----------------------------------------------------------------------------
// ip_alias_table_core: IPv4 address and alias table
// Stores address and alias pairs in a RAM and answers add, alias lookup,
// locality and size items with a sequencer that scans the table entry by entry (but for size items).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ip_alias_table_core #(
   parameter int TABLE_DEPTH = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output      logic                  req_stall,
   input  wire ipat_pkg::req_item_type req_item,
   output      logic                  rsp_valid,
   input  wire logic                  rsp_stall,
   output      ipat_pkg::rsp_item_type rsp_item
);

   // Index width for the RAM and count width that can also hold the depth.
   localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   // Sequencer states.
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_DONE = 2'd2;

   logic [1:0]  state_ff,     state_in;
   logic [CW-1:0] cnt_ff,     cnt_in;
   logic [CW-1:0] left_ff,    left_in;
   logic        rd_vld_ff,    rd_vld_in;
   logic [IW-1:0] rd_idx_ff,  rd_idx_in;
   logic [1:0]  op_ff,        op_in;
   logic [31:0] ip_ff,        ip_in;
   logic [79:0] alias_ff,     alias_in;
   logic        addr_hit_ff,  addr_hit_in;
   logic        alias_hit_ff, alias_hit_in;
   ipat_pkg::entry_type pend_ff, pend_in;
   logic        pend_vld_ff,  pend_vld_in;
   ipat_pkg::rsp_item_type rsp_ff, rsp_in;
   logic        rsp_valid_ff, rsp_valid_in;

   // RAM signals.
   logic                          ram_wr_en;
   logic [IW-1:0]                 ram_wr_addr;
   logic [ipat_pkg::ENTRY_BITS-1:0] ram_wr_data;
   logic [IW-1:0]                 ram_rd_addr;
   logic [ipat_pkg::ENTRY_BITS-1:0] ram_rd_data;

   ipat_pkg::entry_type rd_entry;
   ipat_pkg::entry_type new_entry;
   logic [CW-1:0] idx_next;
   logic        addr_eq;
   logic        alias_eq;
   logic        loc_eq;
   logic        out_free;
   logic        scan_stall;
   logic        lookup_hit;

   assign rd_entry = ipat_pkg::entry_type'(ram_rd_data);
   assign idx_next = left_ff - CW'(1);

   // The shared compare unit: one stored entry against the held item.
   assign addr_eq  = (rd_entry.address == ip_ff);
   assign alias_eq = ({rd_entry.alias_head, rd_entry.alias_tail} == alias_ff);
   assign loc_eq   = (rd_entry.address[31:16] == ip_ff[31:16]);

   // The result register can take a new item when empty or being emptied.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // A locality match waits when an older match still needs the result register.
   assign scan_stall = (state_ff == S_SCAN) && (op_ff == ipat_pkg::OP_LOCAL) &&
                       rd_vld_ff && loc_eq && pend_vld_ff && !out_free;
   assign lookup_hit = (state_ff == S_SCAN) && (op_ff == ipat_pkg::OP_LOOKUP) &&
                       rd_vld_ff && alias_eq;

   // While stalled the same entry is read again, so the read data holds.
   assign ram_rd_addr = scan_stall ? rd_idx_ff : idx_next[IW-1:0];

   assign new_entry.address    = ip_ff;
   assign new_entry.alias_head = alias_ff[79:16];
   assign new_entry.alias_tail = alias_ff[15:0];
   assign ram_wr_addr = cnt_ff[IW-1:0];
   assign ram_wr_data = new_entry;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      left_in      = left_ff;
      rd_vld_in    = rd_vld_ff;
      rd_idx_in    = rd_idx_ff;
      op_in        = op_ff;
      ip_in        = ip_ff;
      alias_in     = alias_ff;
      addr_hit_in  = addr_hit_ff;
      alias_hit_in = alias_hit_ff;
      pend_in      = pend_ff;
      pend_vld_in  = pend_vld_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      ram_wr_en    = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in        = req_item.opcode;
               ip_in        = req_item.ip_address;
               alias_in     = ipat_pkg::normalize_alias(req_item.alias_head,
                                                        req_item.alias_tail);
               left_in      = cnt_ff;
               rd_vld_in    = 1'b0;
               addr_hit_in  = 1'b0;
               alias_hit_in = 1'b0;
               pend_vld_in  = 1'b0;
               state_in     = (req_item.opcode == ipat_pkg::OP_SIZE) ? S_DONE : S_SCAN;
            end
         end

         S_SCAN: begin
            // Evaluate the entry read in the previous cycle.
            if (rd_vld_ff) begin
               case (op_ff)
                  ipat_pkg::OP_ADD: begin
                     addr_hit_in  = addr_hit_ff  || addr_eq;
                     alias_hit_in = alias_hit_ff || alias_eq;
                  end
                  ipat_pkg::OP_LOOKUP: begin
                     if (alias_eq) begin
                        pend_in     = rd_entry;
                        pend_vld_in = 1'b1;
                     end
                  end
                  ipat_pkg::OP_LOCAL: begin
                     if (loc_eq && !scan_stall) begin
                        if (pend_vld_ff) begin
                           rsp_in.status           = ipat_pkg::ST_OK;
                           rsp_in.found_address    = pend_ff.address;
                           rsp_in.found_alias_head = pend_ff.alias_head;
                           rsp_in.found_alias_tail = pend_ff.alias_tail;
                           rsp_in.entry_count      = 6'(cnt_ff);
                           rsp_in.last             = 1'b0;
                           rsp_valid_in            = 1'b1;
                        end
                        pend_in     = rd_entry;
                        pend_vld_in = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end

            // Issue the next read, newest entry first, or finish the scan.
            if (lookup_hit) begin
               rd_vld_in = 1'b0;
               state_in  = S_DONE;
            end else if (!scan_stall) begin
               if (left_ff != '0) begin
                  rd_vld_in = 1'b1;
                  rd_idx_in = idx_next[IW-1:0];
                  left_in   = idx_next;
               end else begin
                  rd_vld_in = 1'b0;
                  state_in  = S_DONE;
               end
            end
         end

         S_DONE: begin
            if (out_free) begin
               rsp_in.status           = ipat_pkg::ST_OK;
               rsp_in.found_address    = '0;
               rsp_in.found_alias_head = '0;
               rsp_in.found_alias_tail = '0;
               rsp_in.last             = 1'b1;
               case (op_ff)
                  ipat_pkg::OP_ADD: begin
                     if (addr_hit_ff) begin
                        rsp_in.status = ipat_pkg::ST_ADDR_EXISTS;
                     end else if (alias_hit_ff) begin
                        rsp_in.status = ipat_pkg::ST_ALIAS_EXISTS;
                     end else if (cnt_ff == CW'(TABLE_DEPTH)) begin
                        rsp_in.status = ipat_pkg::ST_FULL;
                     end else begin
                        ram_wr_en = 1'b1;
                        cnt_in    = cnt_ff + CW'(1);
                     end
                  end
                  ipat_pkg::OP_LOOKUP, ipat_pkg::OP_LOCAL: begin
                     if (pend_vld_ff) begin
                        rsp_in.found_address    = pend_ff.address;
                        rsp_in.found_alias_head = pend_ff.alias_head;
                        rsp_in.found_alias_tail = pend_ff.alias_tail;
                     end else begin
                        rsp_in.status = ipat_pkg::ST_NOT_FOUND;
                     end
                  end
                  default: begin
                  end
               endcase
               rsp_in.entry_count = 6'(cnt_in);
               rsp_valid_in       = 1'b1;
               pend_vld_in        = 1'b0;
               state_in           = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         left_ff      <= '0;
         rd_vld_ff    <= 1'b0;
         pend_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         addr_hit_ff  <= 1'b0;
         alias_hit_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         left_ff      <= left_in;
         rd_vld_ff    <= rd_vld_in;
         pend_vld_ff  <= pend_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         addr_hit_ff  <= addr_hit_in;
         alias_hit_ff <= alias_hit_in;
      end
      rd_idx_ff <= rd_idx_in;
      op_ff     <= op_in;
      ip_ff     <= ip_in;
      alias_ff  <= alias_in;
      pend_ff   <= pend_in;
      rsp_ff    <= rsp_in;
   end

   ipat_ram #(
      .DATA_WIDTH (ipat_pkg::ENTRY_BITS),
      .DEPTH      (TABLE_DEPTH),
      .ADDR_WIDTH (IW)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

`ifndef SYNTH
   // The entry count never exceeds the table depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(TABLE_DEPTH))
      else $error("entry count beyond table depth");

   // The count only ever grows by one, at the end of a successful add.
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && cnt_ff != $past(cnt_ff)) |->
      (cnt_ff == $past(cnt_ff) + CW'(1) && $past(op_ff) == ipat_pkg::OP_ADD))
      else $error("entry count changed outside an add");

   // A read in flight only exists while scanning.
   a_read_in_scan: assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> state_ff == S_SCAN)
      else $error("table read outstanding outside a scan");

   // A non-final locality item means a newer match is still held back.
   a_pending_behind: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.last) |-> pend_vld_ff)
      else $error("non-final item without a held match");

   // The entry RAM is only written while the sequencer finishes an add.
   a_write_on_add: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (state_ff == S_DONE && op_ff == ipat_pkg::OP_ADD && !addr_hit_ff
                     && !alias_hit_ff))
      else $error("table written outside a successful add");
`endif

endmodule

`default_nettype wire
